FILE: sv/piv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piv_pkg: shared definitions for the priority interrupt vectoring block
// Request codes, source codes, level numbers, register indexes and the
// reset values of the vector registers.
// ----------------------------------------------------------------------------
package piv_pkg;

   // Default sizes of the nexus request store.
   localparam int NexusSlotsDefault = 16;
   localparam int HwLevelsDefault   = 4;

   // Upper bounds fixed by the widths of the slot and level fields.
   localparam int NexusSlotsMax = 16;
   localparam int HwLevelsMax   = 4;

   localparam int LevelWidth  = 5;
   localparam int VectorWidth = 16;
   localparam int SlotWidth   = 4;
   localparam int HwIdxWidth  = 2;
   localparam int CsrIdxWidth = 3;

   typedef logic [LevelWidth-1:0]  level_type;
   typedef logic [VectorWidth-1:0] vector_type;

   typedef enum logic [1:0] {
      REQ_POST = 2'd0,
      REQ_EVAL = 2'd1,
      REQ_ACK  = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      SRC_HALT      = 3'd0,
      SRC_MEMERR    = 3'd1,
      SRC_CRDERR    = 3'd2,
      SRC_CLOCK     = 3'd3,
      SRC_NEXUS     = 3'd4,
      SRC_CON_IN    = 3'd5,
      SRC_CON_OUT   = 3'd6,
      SRC_CON_STORE = 3'd7
   } source_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MEMERR_VEC    = 3'd0,
      CSR_CRDERR_VEC    = 3'd1,
      CSR_CLOCK_VEC     = 3'd2,
      CSR_NEXUS_BASE    = 3'd3,
      CSR_CON_IN_VEC    = 3'd4,
      CSR_CON_OUT_VEC   = 3'd5,
      CSR_CON_STORE_VEC = 3'd6
   } csr_index_type;

   localparam int CsrCount = 7;

   localparam level_type LVL_HALT    = 5'h1F;
   localparam level_type LVL_MEMERR  = 5'h1D;
   localparam level_type LVL_CRDERR  = 5'h1A;
   localparam level_type LVL_CLOCK   = 5'h18;
   localparam level_type LVL_HW_TOP  = 5'h17;
   localparam level_type LVL_HW_BOT  = 5'h14;
   localparam level_type LVL_CONSOLE = 5'h14;
   localparam level_type LVL_NONE    = 5'h00;

   localparam vector_type RST_MEMERR_VEC    = 16'd96;
   localparam vector_type RST_CRDERR_VEC    = 16'd84;
   localparam vector_type RST_CLOCK_VEC     = 16'd192;
   localparam vector_type RST_NEXUS_BASE    = 16'd256;
   localparam vector_type RST_CON_IN_VEC    = 16'd248;
   localparam vector_type RST_CON_OUT_VEC   = 16'd252;
   localparam vector_type RST_CON_STORE_VEC = 16'd240;

endpackage : piv_pkg
`default_nettype wire

FILE: sv/priority_interrupt_vectoring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_interrupt_vectoring: pending interrupt store and level encoder
// Holds the pending hardware and console requests, picks the highest
// eligible level for the CPU and hands out vectors on acknowledge.
// ----------------------------------------------------------------------------
//
// Usage. A command word is presented on the req_ ports together with start;
// it is taken at every rising edge where start is high and busy is low.
// busy never rises, so a command may be issued in every cycle. A word is a
// post (raise or withdraw one request), an evaluate (return the highest
// eligible level for a given CPU IPL and software request mask) or an
// acknowledge (return the vector of a level and clear the request served).
// Every command gives exactly one response word.
//
// The command is captured in an input register, the next cycle updates the
// pending state and loads the response register, and rsp_valid is high for
// that one following cycle. Throughput is one command per cycle, set by the
// single update of the pending state per cycle; each command sees the state
// left by the one before it.
//
// The receiver cannot hold responses off; each response is on the rsp_
// ports for exactly one cycle. Vector registers are written over the csr_
// channel, which is always ready; the user must make writes only while no
// command is in flight, as the block does not enforce this. Synchronous reset
// clears all pending requests, drops any command in flight and loads the
// vector registers with their default values.
module priority_interrupt_vectoring
   import piv_pkg::*;
#(
   parameter int NEXUS_SLOTS = NexusSlotsDefault,
   parameter int HW_LEVELS   = HwLevelsDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Command channel.
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             req_type,
   input  wire logic [2:0]             req_source,
   input  wire logic                   req_set_request,
   input  wire logic [HwIdxWidth-1:0]  req_nexus_level,
   input  wire logic [SlotWidth-1:0]   req_nexus_slot,
   input  wire logic [LevelWidth-1:0]  req_cpu_ipl,
   input  wire logic [15:0]            req_soft_requests,
   input  wire logic [LevelWidth-1:0]  req_ack_level,
   // Response channel.
   output logic                        rsp_valid,
   output logic [LevelWidth-1:0]       rsp_int_level,
   output logic [VectorWidth-1:0]      rsp_vector,
   output logic                        rsp_bad_level,
   // Register write channel.
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [VectorWidth-1:0] csr_wdata
);

   // Vector registers.
   vector_type csr_ff [CsrCount];

   // Input register.
   logic                  stg_valid_ff;
   req_code_type          stg_type_ff;
   source_type            stg_source_ff;
   logic                  stg_set_ff;
   logic [HwIdxWidth-1:0] stg_nlevel_ff;
   logic [SlotWidth-1:0]  stg_nslot_ff;
   level_type             stg_ipl_ff;
   logic [15:0]           stg_soft_ff;
   level_type             stg_ack_ff;

   // Pending request state.
   logic halt_ff, halt_in;
   logic memerr_ff, memerr_in;
   logic crderr_ff, crderr_in;
   logic clk_ff, clk_in;
   logic con_in_ff, con_in_in;
   logic con_out_ff, con_out_in;
   logic con_store_ff, con_store_in;
   logic [NEXUS_SLOTS-1:0] nexus_ff [HW_LEVELS];
   logic [NEXUS_SLOTS-1:0] nexus_in [HW_LEVELS];

   // Response register.
   logic       rsp_valid_ff;
   level_type  rsp_level_ff, rsp_level_in;
   vector_type rsp_vector_ff, rsp_vector_in;
   logic       rsp_bad_ff, rsp_bad_in;

   // Decoded helpers.
   logic [HwLevelsMax-1:0] hw_any;
   logic [NEXUS_SLOTS-1:0] post_mask;
   logic [NEXUS_SLOTS-1:0] ack_slots;
   logic [NEXUS_SLOTS-1:0] ack_low;
   logic [SlotWidth-1:0]   ack_slot;
   logic [HwIdxWidth-1:0]  ack_idx;
   level_type              soft_level;
   logic                   con_any;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_int_level = rsp_level_ff;
   assign rsp_vector    = rsp_vector_ff;
   assign rsp_bad_level = rsp_bad_ff;

   // Any request at each hardware level; levels beyond the store are empty.
   for (genvar g = 0; g < HwLevelsMax; g++) begin : g_hw_any
      if (g < HW_LEVELS) begin : g_real
         assign hw_any[g] = |nexus_ff[g];
      end else begin : g_empty
         assign hw_any[g] = 1'b0;
      end
   end

   assign con_any = con_in_ff | con_out_ff | con_store_ff;

   // The hardware level index is the low two bits of levels 0x14 to 0x17.
   assign ack_idx = stg_ack_ff[HwIdxWidth-1:0];

   always_comb begin
      post_mask = '0;
      for (int s = 0; s < NEXUS_SLOTS; s++) begin
         post_mask[s] = (stg_nslot_ff == SlotWidth'(s));
      end
   end

   // Slots requesting at the acknowledged level, and the lowest of them.
   always_comb begin
      ack_slots = '0;
      for (int l = 0; l < HW_LEVELS; l++) begin
         if (ack_idx == HwIdxWidth'(l)) begin
            ack_slots = nexus_ff[l];
         end
      end
      ack_low  = ack_slots & (~ack_slots + NEXUS_SLOTS'(1));
      ack_slot = '0;
      for (int s = NEXUS_SLOTS - 1; s >= 0; s--) begin
         if (ack_slots[s]) begin
            ack_slot = SlotWidth'(s);
         end
      end
   end

   // Highest software level above the IPL; bit 0 never qualifies.
   always_comb begin
      soft_level = LVL_NONE;
      for (int i = 1; i < 16; i++) begin
         if (stg_soft_ff[i] && (stg_ipl_ff < LevelWidth'(i))) begin
            soft_level = LevelWidth'(i);
         end
      end
   end

   // Single-pass command execution against the current pending state.
   always_comb begin
      halt_in       = halt_ff;
      memerr_in     = memerr_ff;
      crderr_in     = crderr_ff;
      clk_in        = clk_ff;
      con_in_in     = con_in_ff;
      con_out_in    = con_out_ff;
      con_store_in  = con_store_ff;
      nexus_in      = nexus_ff;
      rsp_level_in  = LVL_NONE;
      rsp_vector_in = '0;
      rsp_bad_in    = 1'b0;
      if (stg_valid_ff) begin
         unique case (stg_type_ff)
            REQ_POST: begin
               unique case (stg_source_ff)
                  SRC_HALT:      halt_in      = stg_set_ff;
                  SRC_MEMERR:    memerr_in    = stg_set_ff;
                  SRC_CRDERR:    crderr_in    = stg_set_ff;
                  SRC_CLOCK:     clk_in       = stg_set_ff;
                  SRC_CON_IN:    con_in_in    = stg_set_ff;
                  SRC_CON_OUT:   con_out_in   = stg_set_ff;
                  SRC_CON_STORE: con_store_in = stg_set_ff;
                  SRC_NEXUS: begin
                     // Out-of-range levels or slots match no row or bit.
                     for (int l = 0; l < HW_LEVELS; l++) begin
                        if (stg_nlevel_ff == HwIdxWidth'(l)) begin
                           if (stg_set_ff) begin
                              nexus_in[l] = nexus_ff[l] | post_mask;
                           end else begin
                              nexus_in[l] = nexus_ff[l] & ~post_mask;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
            REQ_EVAL: begin
               priority if (halt_ff) begin
                  rsp_level_in = LVL_HALT;
               end else if (memerr_ff && (stg_ipl_ff < LVL_MEMERR)) begin
                  rsp_level_in = LVL_MEMERR;
               end else if (crderr_ff && (stg_ipl_ff < LVL_CRDERR)) begin
                  rsp_level_in = LVL_CRDERR;
               end else if (clk_ff && (stg_ipl_ff < LVL_CLOCK)) begin
                  rsp_level_in = LVL_CLOCK;
               end else if (hw_any[3] && (stg_ipl_ff < LVL_HW_BOT + 5'd3)) begin
                  rsp_level_in = LVL_HW_BOT + 5'd3;
               end else if (hw_any[2] && (stg_ipl_ff < LVL_HW_BOT + 5'd2)) begin
                  rsp_level_in = LVL_HW_BOT + 5'd2;
               end else if (hw_any[1] && (stg_ipl_ff < LVL_HW_BOT + 5'd1)) begin
                  rsp_level_in = LVL_HW_BOT + 5'd1;
               end else if (hw_any[0] && (stg_ipl_ff < LVL_HW_BOT)) begin
                  rsp_level_in = LVL_HW_BOT;
               end else if (con_any && (stg_ipl_ff < LVL_CONSOLE)) begin
                  rsp_level_in = LVL_CONSOLE;
               end else begin
                  rsp_level_in = soft_level;
               end
            end
            REQ_ACK: begin
               priority if (stg_ack_ff == LVL_MEMERR) begin
                  memerr_in     = 1'b0;
                  rsp_vector_in = csr_ff[CSR_MEMERR_VEC];
               end else if (stg_ack_ff == LVL_CRDERR) begin
                  crderr_in     = 1'b0;
                  rsp_vector_in = csr_ff[CSR_CRDERR_VEC];
               end else if (stg_ack_ff == LVL_CLOCK) begin
                  clk_in        = 1'b0;
                  rsp_vector_in = csr_ff[CSR_CLOCK_VEC];
               end else if (stg_ack_ff > LVL_HW_TOP) begin
                  // Halt and unknown high levels have no vector.
                  rsp_bad_in = 1'b1;
               end else if ((stg_ack_ff >= LVL_HW_BOT) && (|ack_slots)) begin
                  for (int l = 0; l < HW_LEVELS; l++) begin
                     if (ack_idx == HwIdxWidth'(l)) begin
                        nexus_in[l] = nexus_ff[l] & ~ack_low;
                     end
                  end
                  rsp_vector_in = csr_ff[CSR_NEXUS_BASE]
                                + VectorWidth'({ack_idx, 6'b0})
                                + VectorWidth'({ack_slot, 2'b0});
               end else if ((stg_ack_ff == LVL_CONSOLE) && con_in_ff) begin
                  con_in_in     = 1'b0;
                  rsp_vector_in = csr_ff[CSR_CON_IN_VEC];
               end else if ((stg_ack_ff == LVL_CONSOLE) && con_out_ff) begin
                  con_out_in    = 1'b0;
                  rsp_vector_in = csr_ff[CSR_CON_OUT_VEC];
               end else if ((stg_ack_ff == LVL_CONSOLE) && con_store_ff) begin
                  con_store_in  = 1'b0;
                  rsp_vector_in = csr_ff[CSR_CON_STORE_VEC];
               end else begin
                  rsp_vector_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Vector register writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff[CSR_MEMERR_VEC]    <= RST_MEMERR_VEC;
         csr_ff[CSR_CRDERR_VEC]    <= RST_CRDERR_VEC;
         csr_ff[CSR_CLOCK_VEC]     <= RST_CLOCK_VEC;
         csr_ff[CSR_NEXUS_BASE]    <= RST_NEXUS_BASE;
         csr_ff[CSR_CON_IN_VEC]    <= RST_CON_IN_VEC;
         csr_ff[CSR_CON_OUT_VEC]   <= RST_CON_OUT_VEC;
         csr_ff[CSR_CON_STORE_VEC] <= RST_CON_STORE_VEC;
      end else if (csr_valid && csr_ready) begin
         for (int r = 0; r < CsrCount; r++) begin
            if (csr_index == CsrIdxWidth'(r)) begin
               csr_ff[r] <= csr_wdata;
            end
         end
      end
   end

   // Input register: the valid bit is control, the fields are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         stg_type_ff   <= req_code_type'(req_type);
         stg_source_ff <= source_type'(req_source);
         stg_set_ff    <= req_set_request;
         stg_nlevel_ff <= req_nexus_level;
         stg_nslot_ff  <= req_nexus_slot;
         stg_ipl_ff    <= req_cpu_ipl;
         stg_soft_ff   <= req_soft_requests;
         stg_ack_ff    <= req_ack_level;
      end
   end

   // Pending state and response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         halt_ff      <= 1'b0;
         memerr_ff    <= 1'b0;
         crderr_ff    <= 1'b0;
         clk_ff       <= 1'b0;
         con_in_ff    <= 1'b0;
         con_out_ff   <= 1'b0;
         con_store_ff <= 1'b0;
         for (int l = 0; l < HW_LEVELS; l++) begin
            nexus_ff[l] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         halt_ff      <= halt_in;
         memerr_ff    <= memerr_in;
         crderr_ff    <= crderr_in;
         clk_ff       <= clk_in;
         con_in_ff    <= con_in_in;
         con_out_ff   <= con_out_in;
         con_store_ff <= con_store_in;
         nexus_ff     <= nexus_in;
         rsp_valid_ff <= stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff  <= rsp_level_in;
      rsp_vector_ff <= rsp_vector_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   // Every response word is preceded by an accepted command.
   a_rsp_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without a command two cycles earlier");

   // A bad level report carries neither a vector nor a level.
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_level) |-> (rsp_vector == '0 && rsp_int_level == LVL_NONE))
      else $error("bad level response with nonzero payload");

   // A pending halt wins every evaluate.
   a_halt_wins: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && stg_type_ff == REQ_EVAL && halt_ff)
      |=> (rsp_valid && rsp_int_level == LVL_HALT))
      else $error("pending halt not reported");

   // Acknowledging the memory error level clears its request.
   a_memerr_cleared: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && stg_type_ff == REQ_ACK && stg_ack_ff == LVL_MEMERR)
      |=> !memerr_ff)
      else $error("memory error request survived its acknowledge");

endmodule : priority_interrupt_vectoring
`default_nettype wire
